/* design/fbha_pkg.sv */
package fbha_pkg;

  // Widths of the fixed transaction fields
  localparam int unsigned OP_W     = 1;
  localparam int unsigned SIZE_W   = 21;
  localparam int unsigned ADDR_W   = 20;
  localparam int unsigned TOTAL_W  = 21;
  // Table entries and internal byte arithmetic are carried at 32 bits
  localparam int unsigned CALC_W   = 32;

  localparam int unsigned DEF_HEAP_BYTES   = 1048576;
  localparam int unsigned DEF_HEADER_BYTES = 32;
  localparam int unsigned DEF_MAX_FREE     = 64;
  localparam int unsigned DEF_MAX_USED     = 64;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_REUSE    = 3'd0,
    ST_EXTEND   = 3'd1,
    ST_NO_HEAP  = 3'd2,
    ST_FULL     = 3'd3,
    ST_UNKNOWN  = 3'd4
  } status_e;

  typedef struct packed {
    op_e               operation;
    logic [SIZE_W-1:0] alloc_size;
    logic [ADDR_W-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  result_address;
    status_e            status;
    logic [TOTAL_W-1:0] segment_size;
    logic [TOTAL_W-1:0] free_space;
  } rsp_t;

  // One table entry: start offset and payload length
  typedef struct packed {
    logic [CALC_W-1:0] start;
    logic [CALC_W-1:0] len;
  } entry_t;

  // What every cell of a row does when clocked
  typedef enum logic [2:0] {
    CM_HOLD    = 3'd0,
    CM_ROT     = 3'd1,
    CM_WRITE   = 3'd2,
    CM_DROP    = 3'd3,
    CM_DROP_WR = 3'd4,
    CM_INSERT  = 3'd5
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
    entry_t     wdata;
  } cell_ctl_t;

endpackage

/* design/first_best_fit_heap_allocator_unit.sv */
// Heap allocator with address-ordered free table and block coalescing.
//
// Request channel: present req_i with start high while busy is low; that
// edge accepts the transaction (allocate or free). Configuration: cfg_we_i
// writes cfg_wdata_i (fit policy, 0 first fit, 1 best fit); the user must
// write it only while idle, as the block does not enforce this. Result
// channel: result_valid_o is high for exactly one cycle with rsp_o; the
// receiver cannot stall it, so it must take the result in that cycle.
//
// The free and used tables are rings of cells that rotate once past the
// controller per request (one entry per cycle), followed by an update
// step in which the cells shift, insert or overwrite in parallel. One
// request at a time.
//
// Reset clears counts, heap top and totals; table contents are not cleared
// and are only read below their counts.
module first_best_fit_heap_allocator_unit #(
  parameter int unsigned HEAP_BYTES   = fbha_pkg::DEF_HEAP_BYTES,
  parameter int unsigned HEADER_BYTES = fbha_pkg::DEF_HEADER_BYTES,
  parameter int unsigned MAX_FREE     = fbha_pkg::DEF_MAX_FREE,
  parameter int unsigned MAX_USED     = fbha_pkg::DEF_MAX_USED
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  fbha_pkg::req_t req_i,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  output logic           result_valid_o,
  output fbha_pkg::rsp_t rsp_o
);
  import fbha_pkg::*;

  localparam int unsigned MAXS = (MAX_FREE > MAX_USED) ? MAX_FREE : MAX_USED;
  localparam int unsigned KW   = $clog2(MAXS + 1);
  localparam int unsigned FCW  = $clog2(MAX_FREE + 1);
  localparam int unsigned UCW  = $clog2(MAX_USED + 1);
  localparam int unsigned FPW  = (MAX_FREE > 1) ? $clog2(MAX_FREE) : 1;
  localparam int unsigned UPW  = (MAX_USED > 1) ? $clog2(MAX_USED) : 1;
  localparam logic [CALC_W-1:0] HDR  = CALC_W'(HEADER_BYTES);
  localparam logic [CALC_W-1:0] HEAP = CALC_W'(HEAP_BYTES);
  localparam logic [KW-1:0]  K_LAST   = KW'(MAXS - 1);
  localparam logic [KW-1:0]  K_FDEPTH = KW'(MAX_FREE);
  localparam logic [KW-1:0]  K_UDEPTH = KW'(MAX_USED);
  localparam logic [FCW-1:0] F_FULL   = FCW'(MAX_FREE);
  localparam logic [UCW-1:0] U_FULL   = UCW'(MAX_USED);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_APPLY = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [KW-1:0]      k_q;
  logic               fit_q;
  logic [FCW-1:0]     free_cnt_q, free_cnt_d;
  logic [UCW-1:0]     used_cnt_q, used_cnt_d;
  logic [CALC_W-1:0]  heap_top_q, heap_top_d;
  logic [TOTAL_W-1:0] seg_q, seg_d, ftot_q, ftot_d;

  // Latched request and scan results
  req_t              req_q;
  logic              found_q, done_q, posf_q, uf_q;
  logic [FCW-1:0]    pick_q, pos_q;
  logic [UCW-1:0]    u_q;
  entry_t            pick_q_e, next_q, prev_q;
  logic [CALC_W-1:0] ulen_q;

  entry_t    free_head, used_head;
  cell_ctl_t free_ctl, used_ctl;
  logic [FCW-1:0] free_pos;
  logic [UCW-1:0] used_pos;
  rsp_t      rsp_d;

  logic [CALC_W-1:0] size32, addr32, fhdr;
  logic              k_in_free, k_in_used;

  assign size32 = CALC_W'(req_q.alloc_size);
  assign addr32 = CALC_W'(req_q.block_address);
  assign fhdr   = addr32 - HDR;
  assign k_in_free = k_q < KW'(free_cnt_q);
  assign k_in_used = k_q < KW'(used_cnt_q);
  assign busy = (state_q != S_IDLE);

  fbha_chain #(.DEPTH(MAX_FREE)) u_free (
    .clk_i  (clk_i),
    .ctl_i  (free_ctl),
    .pos_i  (free_pos[FPW-1:0]),
    .head_o (free_head)
  );

  fbha_chain #(.DEPTH(MAX_USED)) u_used (
    .clk_i  (clk_i),
    .ctl_i  (used_ctl),
    .pos_i  (used_pos[UPW-1:0]),
    .head_o (used_head)
  );

  // Table commands and state updates for the scan and update cycles
  always_comb begin
    logic [CALC_W-1:0] hdr, rlen, tmp;
    logic              mn, mp;
    hdr  = '0;
    rlen = '0;
    tmp  = '0;
    mn   = 1'b0;
    mp   = 1'b0;
    state_d    = state_q;
    free_ctl   = '{mode: CM_HOLD, wdata: '0};
    used_ctl   = '{mode: CM_HOLD, wdata: '0};
    free_pos   = '0;
    used_pos   = '0;
    free_cnt_d = free_cnt_q;
    used_cnt_d = used_cnt_q;
    heap_top_d = heap_top_q;
    seg_d      = seg_q;
    ftot_d     = ftot_q;
    rsp_d      = '{result_address: '0, status: ST_REUSE,
                   segment_size: '0, free_space: '0};
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (k_q < K_FDEPTH) free_ctl.mode = CM_ROT;
        if (k_q < K_UDEPTH) used_ctl.mode = CM_ROT;
        if (k_q == K_LAST) state_d = S_APPLY;
      end
      S_APPLY: begin
        state_d = S_IDLE;
        if (req_q.operation == OP_ALLOC) begin
          if (used_cnt_q >= U_FULL) begin
            rsp_d.status = ST_FULL;
          end else if (found_q) begin
            hdr  = pick_q_e.start;
            free_pos = pick_q;
            if (pick_q_e.len > size32 + HDR) begin
              free_ctl = '{mode: CM_WRITE,
                           wdata: '{start: hdr + HDR + size32,
                                    len: pick_q_e.len - size32 - HDR}};
              tmp  = size32 + HDR;
              rlen = size32;
            end else begin
              free_ctl.mode = CM_DROP;
              free_cnt_d = free_cnt_q - FCW'(1);
              tmp  = pick_q_e.len + HDR;
              rlen = pick_q_e.len;
            end
            ftot_d = ftot_q - tmp[TOTAL_W-1:0];
            used_ctl = '{mode: CM_WRITE, wdata: '{start: hdr + HDR, len: rlen}};
            used_pos = used_cnt_q;
            used_cnt_d = used_cnt_q + UCW'(1);
            rsp_d.result_address = ADDR_W'(hdr + HDR);
            rsp_d.status = ST_REUSE;
          end else if (heap_top_q + HDR >= HEAP ||
                       heap_top_q + HDR + size32 > HEAP) begin
            rsp_d.status = ST_NO_HEAP;
          end else begin
            hdr = heap_top_q;
            tmp = size32 + HDR;
            heap_top_d = heap_top_q + tmp;
            seg_d = seg_q + tmp[TOTAL_W-1:0];
            used_ctl = '{mode: CM_WRITE, wdata: '{start: hdr + HDR, len: size32}};
            used_pos = used_cnt_q;
            used_cnt_d = used_cnt_q + UCW'(1);
            rsp_d.result_address = ADDR_W'(hdr + HDR);
            rsp_d.status = ST_EXTEND;
          end
        end else begin
          mn = (pos_q < free_cnt_q) && (fhdr + HDR + ulen_q == next_q.start);
          mp = (pos_q != '0) && (prev_q.start + HDR + prev_q.len == fhdr);
          if (!uf_q) begin
            rsp_d.status = ST_UNKNOWN;
          end else if (!mn && !mp && free_cnt_q >= F_FULL) begin
            rsp_d.status = ST_FULL;
          end else begin
            used_ctl.mode = CM_DROP;
            used_pos = u_q;
            used_cnt_d = used_cnt_q - UCW'(1);
            tmp = ulen_q + HDR;
            ftot_d = ftot_q + tmp[TOTAL_W-1:0];
            if (mn && mp) begin
              // Both neighbors absorb the block: grow previous, drop next
              free_ctl = '{mode: CM_DROP_WR,
                           wdata: '{start: prev_q.start,
                                    len: prev_q.len + HDR + ulen_q + HDR + next_q.len}};
              free_pos = pos_q - FCW'(1);
              free_cnt_d = free_cnt_q - FCW'(1);
            end else if (mp) begin
              free_ctl = '{mode: CM_WRITE,
                           wdata: '{start: prev_q.start,
                                    len: prev_q.len + HDR + ulen_q}};
              free_pos = pos_q - FCW'(1);
            end else if (mn) begin
              free_ctl = '{mode: CM_WRITE,
                           wdata: '{start: fhdr, len: ulen_q + HDR + next_q.len}};
              free_pos = pos_q;
            end else begin
              free_ctl = '{mode: CM_INSERT, wdata: '{start: fhdr, len: ulen_q}};
              free_pos = pos_q;
              free_cnt_d = free_cnt_q + FCW'(1);
            end
            rsp_d.status = ST_REUSE;
          end
        end
        rsp_d.segment_size = seg_d;
        rsp_d.free_space   = ftot_d;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      k_q            <= '0;
      fit_q          <= 1'b0;
      free_cnt_q     <= '0;
      used_cnt_q     <= '0;
      heap_top_q     <= '0;
      seg_q          <= '0;
      ftot_q         <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      free_cnt_q     <= free_cnt_d;
      used_cnt_q     <= used_cnt_d;
      heap_top_q     <= heap_top_d;
      seg_q          <= seg_d;
      ftot_q         <= ftot_d;
      result_valid_o <= (state_q == S_APPLY);
      if (cfg_we_i) fit_q <= cfg_wdata_i;
      if (state_q == S_IDLE) k_q <= '0;
      else if (state_q == S_SCAN) k_q <= k_q + KW'(1);
    end
  end

  // Request latch, scan of the table heads and result register
  always_ff @(posedge clk_i) begin
    if (state_q == S_APPLY) rsp_o <= rsp_d;
    if (state_q == S_IDLE && start) begin
      req_q   <= req_i;
      found_q <= 1'b0;
      done_q  <= 1'b0;
      posf_q  <= 1'b0;
      uf_q    <= 1'b0;
      pos_q   <= free_cnt_q;
    end else if (state_q == S_SCAN) begin
      if (k_in_free) begin
        if (!done_q) begin
          if (!fit_q) begin
            if (free_head.len >= size32) begin
              found_q <= 1'b1; done_q <= 1'b1;
              pick_q <= k_q[FCW-1:0]; pick_q_e <= free_head;
            end
          end else if (free_head.len == size32) begin
            found_q <= 1'b1; done_q <= 1'b1;
            pick_q <= k_q[FCW-1:0]; pick_q_e <= free_head;
          end else if (free_head.len > size32 &&
                       (!found_q || free_head.len < pick_q_e.len)) begin
            found_q <= 1'b1;
            pick_q <= k_q[FCW-1:0]; pick_q_e <= free_head;
          end
        end
        if (!posf_q) begin
          if (free_head.start > fhdr) begin
            posf_q <= 1'b1;
            pos_q  <= k_q[FCW-1:0];
            next_q <= free_head;
          end else begin
            prev_q <= free_head;
          end
        end
      end
      if (k_in_used && !uf_q && used_head.start == addr32) begin
        uf_q   <= 1'b1;
        u_q    <= k_q[UCW-1:0];
        ulen_q <= used_head.len;
      end
    end
  end

endmodule

/* design/fbha_cell.sv */
module fbha_cell #(
  parameter int unsigned DEPTH = fbha_pkg::DEF_MAX_FREE,
  parameter int unsigned IDX   = 0,
  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  fbha_pkg::cell_ctl_t ctl_i,
  input  logic [PW-1:0]       pos_i,
  input  fbha_pkg::entry_t    left_i,
  input  fbha_pkg::entry_t    right_i,
  output fbha_pkg::entry_t    data_o
);
  import fbha_pkg::*;

  localparam logic [PW-1:0] MY_IDX = PW'(IDX);

  entry_t data_d, data_q;

  // Pick own, neighbor or written value
  always_comb begin
    data_d = data_q;
    case (ctl_i.mode)
      CM_ROT: data_d = right_i;
      CM_WRITE: begin
        if (MY_IDX == pos_i) data_d = ctl_i.wdata;
      end
      CM_DROP: begin
        if (MY_IDX >= pos_i) data_d = right_i;
      end
      CM_DROP_WR: begin
        if (MY_IDX == pos_i) data_d = ctl_i.wdata;
        else if (MY_IDX > pos_i) data_d = right_i;
      end
      CM_INSERT: begin
        if (MY_IDX == pos_i) data_d = ctl_i.wdata;
        else if (MY_IDX > pos_i) data_d = left_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* design/fbha_chain.sv */
module fbha_chain #(
  parameter int unsigned DEPTH = fbha_pkg::DEF_MAX_FREE,
  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  fbha_pkg::cell_ctl_t ctl_i,
  input  logic [PW-1:0]       pos_i,
  output fbha_pkg::entry_t    head_o
);
  import fbha_pkg::*;

  entry_t cell_data [DEPTH];

  // Ring of cells; rotation moves entry k to the head after k steps
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    fbha_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl_i),
      .pos_i   (pos_i),
      .left_i  (cell_data[(i + DEPTH - 1) % DEPTH]),
      .right_i (cell_data[(i + 1) % DEPTH]),
      .data_o  (cell_data[i])
    );
  end

  assign head_o = cell_data[0];

endmodule

/* design/fbha_checker.sv */
module fbha_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           result_valid_o,
  input fbha_pkg::rsp_t rsp_o
);
  import fbha_pkg::*;

  // An accepted transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accept did not raise busy");

  // One result strobe per transaction, at the end of a busy period
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("strobe longer than a cycle");

  a_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_valid_o) |-> $past(busy) && !busy)
    else $error("result without a finished transaction");

  // Error results return a zero address; frees do too, but this check covers errors only
  a_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && rsp_o.status != ST_REUSE && rsp_o.status != ST_EXTEND
      |-> rsp_o.result_address == '0)
    else $error("address on error result");

endmodule

bind first_best_fit_heap_allocator_unit fbha_checker u_fbha_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .rsp_o          (rsp_o)
);

/* sim/tb_first_best_fit_heap_allocator_unit.sv */
`timescale 1ns / 1ps

module tb_first_best_fit_heap_allocator_unit;
  import fbha_pkg::*;

  localparam int unsigned HEAP   = DEF_HEAP_BYTES;
  localparam int unsigned HDR    = DEF_HEADER_BYTES;
  localparam int unsigned NFREE  = DEF_MAX_FREE;
  localparam int unsigned NUSED  = DEF_MAX_USED;
  localparam int unsigned LATENCY = (NFREE > NUSED ? NFREE : NUSED) + 2;
  localparam int unsigned CYCLE_LIMIT = 600000;

  // Allocator state mirror and queue of predicted responses
  class heap_tracker;
    // one spare slot: a free that merges backward into a full table
    // inserts first and drops right after
    int unsigned free_start[NFREE+1];
    int unsigned free_len[NFREE+1];
    int unsigned free_count;
    int unsigned used_start[NUSED];
    int unsigned used_len[NUSED];
    int unsigned used_count;
    int unsigned heap_top;
    int unsigned seg_total;
    int unsigned free_total;
    bit          best_fit;
    rsp_t        pending_rsp[$];
    int unsigned mismatches;

    function void drop_free(int unsigned i);
      for (; i + 1 < free_count; i++) begin
        free_start[i] = free_start[i+1];
        free_len[i]   = free_len[i+1];
      end
      free_count--;
    endfunction

    function void drop_used(int unsigned i);
      for (; i + 1 < used_count; i++) begin
        used_start[i] = used_start[i+1];
        used_len[i]   = used_len[i+1];
      end
      used_count--;
    endfunction

    function status_e allocate(int unsigned size, output int unsigned addr);
      int unsigned pick, hdr, len;
      bit found;
      pick  = 0;
      found = 0;
      addr  = 0;
      if (used_count >= NUSED) return ST_FULL;
      for (int unsigned i = 0; i < free_count; i++) begin
        len = free_len[i];
        if (!best_fit) begin
          if (len >= size) begin
            pick = i; found = 1; break;
          end
        end else begin
          if (len == size) begin
            pick = i; found = 1; break;
          end
          if (len > size && (!found || len < free_len[pick])) begin
            pick = i; found = 1;
          end
        end
      end
      if (found) begin
        hdr = free_start[pick];
        len = free_len[pick];
        // split off the tail when it can hold more than a header
        if (len > size + HDR) begin
          free_start[pick] = hdr + HDR + size;
          free_len[pick]   = len - size - HDR;
          free_total      -= size + HDR;
          len = size;
        end else begin
          drop_free(pick);
          free_total -= len + HDR;
        end
        used_start[used_count] = hdr + HDR;
        used_len[used_count]   = len;
        used_count++;
        addr = hdr + HDR;
        return ST_REUSE;
      end
      if (heap_top + HDR >= HEAP || heap_top + HDR + size > HEAP) return ST_NO_HEAP;
      hdr = heap_top;
      heap_top  += size + HDR;
      seg_total += size + HDR;
      used_start[used_count] = hdr + HDR;
      used_len[used_count]   = size;
      used_count++;
      addr = hdr + HDR;
      return ST_EXTEND;
    endfunction

    function status_e release_block(int unsigned addr);
      int unsigned u, pos, hdr, len;
      bit nxt, prv;
      for (u = 0; u < used_count; u++)
        if (used_start[u] == addr) break;
      if (u >= used_count) return ST_UNKNOWN;
      hdr = addr - HDR;
      len = used_len[u];
      for (pos = 0; pos < free_count; pos++)
        if (free_start[pos] > hdr) break;
      nxt = pos < free_count && hdr + HDR + len == free_start[pos];
      prv = pos > 0 && free_start[pos-1] + HDR + free_len[pos-1] == hdr;
      if (!nxt && !prv && free_count >= NFREE) return ST_FULL;
      drop_used(u);
      free_total += len + HDR;
      if (nxt) begin
        len += HDR + free_len[pos];
        free_start[pos] = hdr;
        free_len[pos]   = len;
      end else begin
        for (int unsigned k = free_count; k > pos; k--) begin
          free_start[k] = free_start[k-1];
          free_len[k]   = free_len[k-1];
        end
        free_start[pos] = hdr;
        free_len[pos]   = len;
        free_count++;
      end
      if (prv) begin
        free_len[pos-1] += HDR + len;
        drop_free(pos);
      end
      return ST_REUSE;
    endfunction

    // Accepted request: advance the mirror and queue the response
    function void note_request(req_t r);
      rsp_t e;
      int unsigned addr;
      status_e st;
      addr = 0;
      if (r.operation == OP_ALLOC) st = allocate(r.alloc_size, addr);
      else st = release_block(r.block_address);
      if (st > ST_EXTEND) addr = 0;
      e.result_address = addr[ADDR_W-1:0];
      e.status         = st;
      e.segment_size   = seg_total[TOTAL_W-1:0];
      e.free_space     = free_total[TOTAL_W-1:0];
      pending_rsp.push_back(e);
    endfunction

    function void check_result(rsp_t a);
      rsp_t e;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result %p", $time, a);
        mismatches++;
        return;
      end
      e = pending_rsp.pop_front();
      if (a.result_address !== e.result_address) begin
        $display("%0t: result_address exp %0h got %0h", $time, e.result_address,
                 a.result_address);
        mismatches++;
      end
      if (a.status !== e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
        mismatches++;
      end
      if (a.segment_size !== e.segment_size) begin
        $display("%0t: segment_size exp %0d got %0d", $time, e.segment_size,
                 a.segment_size);
        mismatches++;
      end
      if (a.free_space !== e.free_space) begin
        $display("%0t: free_space exp %0d got %0d", $time, e.free_space, a.free_space);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy;
  req_t req = '0;
  logic cfg_we_i = 0;
  logic cfg_wdata_i = 0;
  logic result_valid_o;
  rsp_t rsp_o;

  heap_tracker heap = new();
  int unsigned send_idle_pct;
  int unsigned cycles;

  first_best_fit_heap_allocator_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .result_valid_o(result_valid_o), .rsp_o(rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) heap.check_result(rsp_o);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one transaction, with an optional random gap ahead of it
  task automatic send_req(input req_t r);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    start <= 1;
    req   <= r;
    do @(posedge clk_i); while (busy);
    heap.note_request(r);
  endtask

  task automatic do_alloc(input int unsigned size);
    req_t r;
    r.operation     = OP_ALLOC;
    r.alloc_size    = size[SIZE_W-1:0];
    r.block_address = ADDR_W'($urandom);
    send_req(r);
  endtask

  task automatic do_free(input int unsigned addr);
    req_t r;
    r.operation     = OP_FREE;
    r.alloc_size    = SIZE_W'($urandom);
    r.block_address = addr[ADDR_W-1:0];
    send_req(r);
  endtask

  // Drain outstanding results, then write the fit policy
  task automatic set_policy(input bit v);
    @(negedge clk_i);
    start <= 0;
    while (heap.pending_rsp.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
    cfg_we_i    <= 1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    heap.best_fit = v;
  endtask

  task automatic random_items(input int unsigned n);
    int unsigned sel;
    for (int unsigned i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 50) do_alloc($urandom_range(0, 256));
      else if (sel < 58) do_alloc($urandom_range(0, 4096));
      else if (sel < 60) do_alloc($urandom_range(0, HEAP));
      else if (sel < 93 && heap.used_count > 0)
        do_free(heap.used_start[$urandom_range(0, heap.used_count - 1)]);
      else if (sel < 97) do_free($urandom);
      else do_free(HDR * $urandom_range(1, 64));
    end
  endtask

  initial begin
    int unsigned a0;
    send_idle_pct = 25;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // Directed: extremes, splits, merges, exact fit, errors
    set_policy(0);
    do_alloc(0);
    do_alloc(HEAP);
    do_alloc(100);
    do_alloc(200);
    do_alloc(64);
    do_alloc(300);
    do_free(HDR + 32);
    do_free(HDR);
    do_free(HDR + 32 + 100 + HDR);
    do_free(HDR);
    do_free(20'hFFFFF);
    do_alloc(10);
    do_alloc(200);
    set_policy(1);
    a0 = heap.used_start[heap.used_count - 1];
    do_free(a0);
    do_alloc(64);
    do_alloc(5);
    do_alloc(HEAP - 2000);
    do_alloc(HEAP);
    do_alloc(21'h0FFFFF);

    random_items(250);
    set_policy(0);
    send_idle_pct = 74;
    random_items(250);
    set_policy(1);
    send_idle_pct = 0;
    random_items(250);

    @(negedge clk_i);
    start <= 0;
    while (heap.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    if (heap.mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
